// File: design/mrht_pkg.sv
// mrht_pkg: shared types and constants of the mac remap hash table
// no dependencies; imported by the channel interfaces and the core
`timescale 1ns / 1ps

package mrht_pkg;

  localparam int MAC_W = 48;
  localparam int PAY_W = 64;
  localparam int ID_W  = 8;
  localparam int CNT_OUT_W = 8;

  // apb register map: byte address 4*i, index in paddr[CFG_AW-1:2]
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_HASH_SALT = '0;

  // jhash initial value offset: 0xdeadbeef plus the key length of four bytes
  localparam logic [31:0] HASH_IV = 32'hDEADBEF3;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_RSVD     = 2'd3
  } status_t;

endpackage

// File: design/mrht_in_if.sv
// mrht_in_if: request channel, valid/ready with one request per beat
// depends on mrht_pkg
`timescale 1ns / 1ps

interface mrht_in_if import mrht_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [MAC_W-1:0]   match_mac;
  logic [MAC_W-1:0]   new_mac;
  logic [ID_W-1:0]    filter_id;
  logic [ID_W-1:0]    port_id;

  modport source (output valid, kind, match_mac, new_mac, filter_id, port_id,
                  input ready);
  modport sink   (input valid, kind, match_mac, new_mac, filter_id, port_id,
                  output ready);
endinterface

// File: design/mrht_out_if.sv
// mrht_out_if: result channel, valid/ready with one result per beat
// depends on mrht_pkg
`timescale 1ns / 1ps

interface mrht_out_if import mrht_pkg::*; ();
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [MAC_W-1:0]     out_mac;
  logic [ID_W-1:0]      out_filter;
  logic [ID_W-1:0]      out_port;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, out_mac, out_filter, out_port, entry_count,
                  input ready);
  modport sink   (input valid, status, out_mac, out_filter, out_port, entry_count,
                  output ready);
endinterface

// File: design/mac_remap_hash_table_core.sv
// mac_remap_hash_table_core: mac remap table, chained hash buckets in memories,
// one shared jhash mixing unit under a sequencer; depends on mrht_pkg,
// mrht_in_if and mrht_out_if
// sequence: seed, key add, mixing steps, bucket read, then one entry memory read
//   per chain entry visited; a delete adds a free-list step, an insert a slot step
// throughput: one request at a time, ready only in idle; a held result delays the next
// clear: one bucket cleared per cycle over all 2^BUCKET_BITS buckets
// reset: synchronous; a pass clearing all buckets follows, no
//   request beat taken meanwhile, config writes taken as ever
`timescale 1ns / 1ps

module mac_remap_hash_table_core
  import mrht_pkg::*;
#(
  parameter int MAX_ENTRIES = 128,
  parameter int BUCKET_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  mrht_in_if.sink           in_chan,
  mrht_out_if.source        out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NB = 1 << BUCKET_BITS;

  typedef struct packed {
    logic [PAY_W-1:0] pay;
    logic [MAC_W-1:0] key;
    logic             nok;
    logic [SW-1:0]    nxt;
  } ent_t;

  typedef struct packed {
    logic          ok;
    logic [SW-1:0] link;
  } bkt_t;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_IV, S_KEY, S_MIX, S_BRD, S_BCHK, S_WALK,
    S_ECHK, S_HIT, S_FREE, S_MISS, S_POPW, S_INS, S_DONE
  } state_t;

  // config register
  logic [31:0] salt_r;
  logic        cfg_sel;

  assign cfg_sel    = (cfg_paddr[CFG_AW-1:2] == REG_HASH_SALT);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_sel ? salt_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel) begin
      salt_r <= cfg_pwdata;
    end
  end

  // sequencer registers
  state_t               state_r;
  logic [BUCKET_BITS-1:0] sweep_r;
  logic                 clr_r;
  kind_t                kind_r;
  logic [MAC_W-1:0]     mac_r;
  logic [PAY_W-1:0]     pay_r;
  logic [31:0]          a_r, b_r, c_r;
  logic [2:0]           step_r;
  logic [BUCKET_BITS-1:0] h_r;
  logic                 cur_ok_r;
  logic [SW-1:0]        cur_r;
  logic                 has_prev_r;
  logic [SW-1:0]        prev_r;
  ent_t                 prev_word_r;
  logic [SW-1:0]        slot_r;
  logic [SW-1:0]        free_head_r;
  logic                 free_ok_r;
  logic [CW-1:0]        hwm_r;
  logic [CW-1:0]        count_r;
  status_t              status_r;
  logic [PAY_W-1:0]     res_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [PAY_W-1:0]     out_res_r;
  logic [CNT_OUT_W-1:0] out_count_r;

  // memories
  ent_t                 ent_mem [MAX_ENTRIES];
  bkt_t                 bkt_mem [NB];
  ent_t                 ent_rd_r;
  bkt_t                 bkt_rd_r;

  logic                 ent_we, ent_re;
  logic [SW-1:0]        ent_waddr, ent_raddr;
  ent_t                 ent_wdata;
  logic                 bkt_we, bkt_re;
  logic [BUCKET_BITS-1:0] bkt_waddr, bkt_raddr;
  bkt_t                 bkt_wdata;

  logic [31:0]          hash_key;
  logic [31:0]          mix_src, mix_dst, mix_rot, mix_res;
  logic                 full;

  assign hash_key = {mac_r[7:0], mac_r[15:8], mac_r[23:16], mac_r[31:24]};
  assign full     = (count_r == CW'(MAX_ENTRIES));

  // shared mixing unit: dst = (dst ^ src) - rotl(src, r)
  always_comb begin
    mix_src = b_r;
    mix_dst = c_r;
    mix_rot = {b_r[17:0], b_r[31:18]};
    case (step_r)
      3'd0: begin mix_src = b_r; mix_dst = c_r; mix_rot = {b_r[17:0], b_r[31:18]}; end
      3'd1: begin mix_src = c_r; mix_dst = a_r; mix_rot = {c_r[20:0], c_r[31:21]}; end
      3'd2: begin mix_src = a_r; mix_dst = b_r; mix_rot = {a_r[6:0], a_r[31:7]}; end
      3'd3: begin mix_src = b_r; mix_dst = c_r; mix_rot = {b_r[15:0], b_r[31:16]}; end
      3'd4: begin mix_src = c_r; mix_dst = a_r; mix_rot = {c_r[27:0], c_r[31:28]}; end
      3'd5: begin mix_src = a_r; mix_dst = b_r; mix_rot = {a_r[17:0], a_r[31:18]}; end
      3'd6: begin mix_src = b_r; mix_dst = c_r; mix_rot = {b_r[7:0], b_r[31:8]}; end
      default: begin mix_src = b_r; mix_dst = c_r; mix_rot = b_r; end
    endcase
    mix_res = (mix_dst ^ mix_src) - mix_rot;
  end

  // memory port control
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = cur_r;
    ent_wdata = ent_rd_r;
    ent_re    = 1'b0;
    ent_raddr = cur_r;
    bkt_we    = 1'b0;
    bkt_waddr = h_r;
    bkt_wdata = '0;
    bkt_re    = 1'b0;
    bkt_raddr = c_r[BUCKET_BITS-1:0];
    case (state_r)
      S_SWEEP: begin
        bkt_we    = 1'b1;
        bkt_waddr = sweep_r;
      end
      S_BRD: bkt_re = 1'b1;
      S_WALK: ent_re = cur_ok_r;
      S_HIT: begin
        case (kind_r)
          KIND_UPDATE: begin
            ent_we        = 1'b1;
            ent_wdata.pay = pay_r;
          end
          KIND_DELETE: begin
            if (has_prev_r) begin
              ent_we        = 1'b1;
              ent_waddr     = prev_r;
              ent_wdata     = prev_word_r;
              ent_wdata.nok = ent_rd_r.nok;
              ent_wdata.nxt = ent_rd_r.nxt;
            end else begin
              bkt_we    = 1'b1;
              bkt_wdata = '{ok: ent_rd_r.nok, link: ent_rd_r.nxt};
            end
          end
          default: ;
        endcase
      end
      S_FREE: begin
        ent_we        = 1'b1;
        ent_wdata.nok = free_ok_r;
        ent_wdata.nxt = free_head_r;
      end
      S_MISS: begin
        ent_re    = (kind_r == KIND_UPDATE) && !full && free_ok_r;
        ent_raddr = free_head_r;
      end
      S_INS: begin
        ent_we    = 1'b1;
        ent_waddr = slot_r;
        ent_wdata = '{pay: pay_r, key: mac_r, nok: bkt_rd_r.ok, nxt: bkt_rd_r.link};
        bkt_we    = 1'b1;
        bkt_wdata = '{ok: 1'b1, link: slot_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rd_r <= bkt_mem[bkt_raddr];
    end
  end

  assign in_chan.ready        = (state_r == S_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.out_mac     = out_res_r[MAC_W-1:0];
  assign out_chan.out_filter  = out_res_r[MAC_W+ID_W-1:MAC_W];
  assign out_chan.out_port    = out_res_r[PAY_W-1:MAC_W+ID_W];
  assign out_chan.entry_count = out_count_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      clr_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      hwm_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_SWEEP: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == BUCKET_BITS'(NB - 1)) begin
            clr_r    <= 1'b0;
            status_r <= STAT_OK;
            res_r    <= '0;
            state_r  <= clr_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_chan.valid) begin
            kind_r <= in_chan.kind;
            mac_r  <= in_chan.match_mac;
            pay_r  <= {in_chan.port_id, in_chan.filter_id, in_chan.new_mac};
            if (in_chan.kind == KIND_CLEAR) begin
              clr_r     <= 1'b1;
              sweep_r   <= '0;
              count_r   <= '0;
              hwm_r     <= '0;
              free_ok_r <= 1'b0;
              state_r   <= S_SWEEP;
            end else begin
              state_r <= S_IV;
            end
          end
        end
        S_IV: begin
          b_r     <= salt_r + HASH_IV;
          c_r     <= salt_r + HASH_IV;
          state_r <= S_KEY;
        end
        S_KEY: begin
          a_r     <= hash_key + b_r;
          step_r  <= '0;
          state_r <= S_MIX;
        end
        S_MIX: begin
          case (step_r)
            3'd1, 3'd4: a_r <= mix_res;
            3'd2, 3'd5: b_r <= mix_res;
            default:    c_r <= mix_res;
          endcase
          step_r <= step_r + 1'b1;
          if (step_r == 3'd6) begin
            state_r <= S_BRD;
          end
        end
        S_BRD: begin
          h_r     <= c_r[BUCKET_BITS-1:0];
          state_r <= S_BCHK;
        end
        S_BCHK: begin
          cur_ok_r   <= bkt_rd_r.ok;
          cur_r      <= bkt_rd_r.link;
          has_prev_r <= 1'b0;
          state_r    <= S_WALK;
        end
        S_WALK: begin
          state_r <= cur_ok_r ? S_ECHK : S_MISS;
        end
        S_ECHK: begin
          if (ent_rd_r.key == mac_r) begin
            state_r <= S_HIT;
          end else begin
            prev_r      <= cur_r;
            prev_word_r <= ent_rd_r;
            has_prev_r  <= 1'b1;
            cur_ok_r    <= ent_rd_r.nok;
            cur_r       <= ent_rd_r.nxt;
            state_r     <= S_WALK;
          end
        end
        S_HIT: begin
          status_r <= STAT_OK;
          res_r    <= (kind_r == KIND_UPDATE) ? pay_r : ent_rd_r.pay;
          state_r  <= (kind_r == KIND_DELETE) ? S_FREE : S_DONE;
        end
        S_FREE: begin
          free_head_r <= cur_r;
          free_ok_r   <= 1'b1;
          count_r     <= count_r - 1'b1;
          state_r     <= S_DONE;
        end
        S_MISS: begin
          res_r <= '0;
          if (kind_r != KIND_UPDATE) begin
            status_r <= STAT_NOTFOUND;
            state_r  <= S_DONE;
          end else if (full) begin
            status_r <= STAT_FULL;
            state_r  <= S_DONE;
          end else if (free_ok_r) begin
            state_r <= S_POPW;
          end else begin
            slot_r  <= hwm_r[SW-1:0];
            hwm_r   <= hwm_r + 1'b1;
            state_r <= S_INS;
          end
        end
        S_POPW: begin
          slot_r      <= free_head_r;
          free_head_r <= ent_rd_r.nxt;
          free_ok_r   <= ent_rd_r.nok;
          state_r     <= S_INS;
        end
        S_INS: begin
          count_r  <= count_r + 1'b1;
          status_r <= STAT_OK;
          res_r    <= pay_r;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_res_r    <= res_r;
            out_count_r  <= CNT_OUT_W'(count_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
